// File: rtl/mdrp_pkg.sv
// ----------------------------------------------------------------------------
// mdrp_pkg
// Shared types, constants and helper functions of the data record parser.
// ----------------------------------------------------------------------------
package mdrp_pkg;

  localparam int MAX_EXT = 11;
  localparam int EXT_W   = $clog2(MAX_EXT + 1);
  localparam int POS_W   = 16;

  localparam int STOR_W  = 45;
  localparam int TAR_W   = 22;
  localparam int SUB_W   = 11;
  localparam int SIZE_W  = 9;
  localparam int START_W = 16;

  localparam logic [7:0] FILLER_BYTE  = 8'h2F;
  localparam logic [3:0] CODE_VARLEN  = 4'hD;
  localparam logic [7:0] CI_COMPACT_A = 8'h73;
  localparam logic [7:0] CI_COMPACT_B = 8'h79;
  localparam logic [7:0] CI_COMPACT_C = 8'h7B;
  localparam logic [7:0] CI_FORMAT_A  = 8'h69;
  localparam logic [7:0] CI_FORMAT_B  = 8'h6A;
  localparam logic [7:0] CI_FORMAT_C  = 8'h6B;
  localparam logic [1:0] HDR_SKIP     = 2'd3;
  localparam logic [POS_W-1:0] FMT_POS_INIT = POS_W'(4);

  typedef enum logic [2:0] {
    PH_DIF  = 3'd0,
    PH_DIFX = 3'd1,
    PH_VIF  = 3'd2,
    PH_VIFX = 3'd3,
    PH_DLEN = 3'd4,
    PH_DATA = 3'd5,
    PH_FLEN = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_FORMAT  = 2'd1,
    MODE_COMPACT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ROLE_FILLER = 3'd0,
    ROLE_DIF    = 3'd1,
    ROLE_DIFX   = 3'd2,
    ROLE_VIF    = 3'd3,
    ROLE_VIFX   = 3'd4,
    ROLE_DATA   = 3'd5,
    ROLE_SKIP   = 3'd6
  } role_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TRUNC   = 2'd1,
    STAT_EXT_OVF = 2'd2
  } status_t;

  typedef struct packed {
    phase_t             phase;
    logic [EXT_W-1:0]   ext_cnt;
    logic [SIZE_W-1:0]  data_rem;
    logic [POS_W-1:0]   byte_pos;
    logic [POS_W-1:0]   fmt_pos;
    logic [1:0]         hdr_skip;
    logic [STOR_W-1:0]  storage;
    logic [TAR_W-1:0]   tariff;
    logic [SUB_W-1:0]   subunit;
    logic [5:0]         dif_code;
    mode_t              mode;
    logic               aborted;
    logic [SIZE_W-1:0]  rec_size;
    logic [POS_W-1:0]   rec_start;
  } state_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] control_info;
  } item_t;

  typedef struct packed {
    role_t               byte_role;
    logic                record_done;
    logic [1:0]          dif_function;
    logic [STOR_W-1:0]   storage_number;
    logic [TAR_W-1:0]    tariff_number;
    logic [SUB_W-1:0]    subunit_number;
    logic [SIZE_W-1:0]   record_data_size;
    logic [START_W-1:0]  record_data_start;
    status_t             parse_status;
  } result_t;

  function automatic state_t frame_init(mode_t mode);
    state_t st;
    st.phase     = PH_DIF;
    st.ext_cnt   = '0;
    st.data_rem  = '0;
    st.byte_pos  = '0;
    st.fmt_pos   = FMT_POS_INIT;
    st.hdr_skip  = '0;
    st.storage   = '0;
    st.tariff    = '0;
    st.subunit   = '0;
    st.dif_code  = '0;
    st.mode      = mode;
    st.aborted   = 1'b0;
    st.rec_size  = '0;
    st.rec_start = '0;
    return st;
  endfunction

  function automatic logic [SIZE_W-1:0] dif_size(logic [3:0] code);
    logic [SIZE_W-1:0] sz;
    case (code)
      4'h0:    sz = SIZE_W'(0);
      4'h1:    sz = SIZE_W'(1);
      4'h2:    sz = SIZE_W'(2);
      4'h3:    sz = SIZE_W'(3);
      4'h4:    sz = SIZE_W'(4);
      4'h5:    sz = SIZE_W'(5);
      4'h6:    sz = SIZE_W'(6);
      4'h7:    sz = SIZE_W'(8);
      4'h8:    sz = SIZE_W'(0);
      4'h9:    sz = SIZE_W'(1);
      4'hA:    sz = SIZE_W'(2);
      4'hB:    sz = SIZE_W'(3);
      4'hC:    sz = SIZE_W'(4);
      4'hE:    sz = SIZE_W'(6);
      default: sz = SIZE_W'(0);
    endcase
    return sz;
  endfunction

endpackage

// File: rtl/mdrp_step.sv
// ----------------------------------------------------------------------------
// mdrp_step
// Combinational parse step: next parser state and tagged result for one byte.
// ----------------------------------------------------------------------------
module mdrp_step (
  input  mdrp_pkg::state_t  st,
  input  mdrp_pkg::item_t   item,
  output mdrp_pkg::state_t  st_nxt,
  output mdrp_pkg::result_t res
);

  typedef struct packed {
    mdrp_pkg::state_t st;
    logic             done;
  } vif_end_t;

  function automatic vif_end_t end_vif(mdrp_pkg::state_t s, logic last);
    vif_end_t         r;
    logic [3:0]       code;
    logic [mdrp_pkg::SIZE_W-1:0] sz;
    r.st   = s;
    r.done = 1'b0;
    code   = s.dif_code[3:0];
    sz     = mdrp_pkg::dif_size(code);
    if (s.mode == mdrp_pkg::MODE_FORMAT) begin
      r.st.rec_start = s.fmt_pos;
      if (code == mdrp_pkg::CODE_VARLEN && !last) begin
        r.st.phase = mdrp_pkg::PH_FLEN;
      end else begin
        if (code == mdrp_pkg::CODE_VARLEN) begin
          sz = mdrp_pkg::SIZE_W'(1);
        end
        r.st.rec_size = sz;
        r.st.fmt_pos  = s.fmt_pos + mdrp_pkg::POS_W'(sz);
        r.st.phase    = mdrp_pkg::PH_DIF;
        r.done        = 1'b1;
      end
    end else begin
      r.st.rec_start = s.byte_pos + mdrp_pkg::POS_W'(1);
      if (code == mdrp_pkg::CODE_VARLEN) begin
        r.st.phase = mdrp_pkg::PH_DLEN;
      end else begin
        r.st.rec_size = sz;
        if (sz == '0) begin
          r.st.phase = mdrp_pkg::PH_DIF;
          r.done     = 1'b1;
        end else begin
          r.st.data_rem = sz;
          r.st.phase    = mdrp_pkg::PH_DATA;
        end
      end
    end
    return r;
  endfunction

  mdrp_pkg::state_t  n;
  mdrp_pkg::mode_t   mode;
  mdrp_pkg::result_t snap;
  vif_end_t          ve;
  logic              snapped;
  logic [7:0]        b;
  logic [5:0]        stor_sh;
  logic [4:0]        tar_sh;

  always_comb begin
    b       = item.payload_byte;
    n       = st;
    snapped = 1'b0;
    ve      = '0;
    res     = '0;
    snap    = '0;
    res.byte_role    = mdrp_pkg::ROLE_SKIP;
    res.parse_status = mdrp_pkg::STAT_OK;
    res.record_done  = 1'b0;
    mode    = mdrp_pkg::MODE_NORMAL;
    stor_sh = {n.ext_cnt, 2'b00} + 6'd1;
    tar_sh  = {n.ext_cnt, 1'b0};

    if (item.first_byte) begin
      if (item.control_info == mdrp_pkg::CI_COMPACT_A ||
          item.control_info == mdrp_pkg::CI_COMPACT_B ||
          item.control_info == mdrp_pkg::CI_COMPACT_C) begin
        mode = mdrp_pkg::MODE_COMPACT;
      end else if (item.control_info == mdrp_pkg::CI_FORMAT_A ||
                   item.control_info == mdrp_pkg::CI_FORMAT_B ||
                   item.control_info == mdrp_pkg::CI_FORMAT_C) begin
        mode = mdrp_pkg::MODE_FORMAT;
      end
      n       = mdrp_pkg::frame_init(mode);
      stor_sh = 6'd1;
      tar_sh  = 5'd0;
    end

    if (n.aborted || (n.mode != mdrp_pkg::MODE_NORMAL &&
                      n.mode != mdrp_pkg::MODE_FORMAT)) begin
      res.byte_role = mdrp_pkg::ROLE_SKIP;
    end else if (n.mode == mdrp_pkg::MODE_FORMAT && n.hdr_skip < mdrp_pkg::HDR_SKIP) begin
      n.hdr_skip    = n.hdr_skip + 2'd1;
      res.byte_role = mdrp_pkg::ROLE_SKIP;
    end else begin
      // A pending length byte closes the previous record and then acts as a DIF or filler.
      if (n.phase == mdrp_pkg::PH_FLEN) begin
        n.rec_size = {1'b0, b} + mdrp_pkg::SIZE_W'(1);
        n.fmt_pos  = n.fmt_pos + mdrp_pkg::POS_W'(n.rec_size);
        n.phase    = mdrp_pkg::PH_DIF;
        res.record_done         = 1'b1;
        snap.dif_function       = n.dif_code[5:4];
        snap.storage_number     = n.storage;
        snap.tariff_number      = n.tariff;
        snap.subunit_number     = n.subunit;
        snap.record_data_size   = n.rec_size;
        snap.record_data_start  = mdrp_pkg::START_W'(n.rec_start);
        snapped                 = 1'b1;
      end
      case (n.phase)
        mdrp_pkg::PH_DIF: begin
          if (b == mdrp_pkg::FILLER_BYTE) begin
            res.byte_role = mdrp_pkg::ROLE_FILLER;
          end else begin
            res.byte_role = mdrp_pkg::ROLE_DIF;
            n.dif_code = b[5:0];
            n.storage  = mdrp_pkg::STOR_W'(b[6]);
            n.tariff   = '0;
            n.subunit  = '0;
            n.ext_cnt  = '0;
            n.rec_size = '0;
            n.phase    = b[7] ? mdrp_pkg::PH_DIFX : mdrp_pkg::PH_VIF;
          end
        end
        mdrp_pkg::PH_DIFX: begin
          res.byte_role = mdrp_pkg::ROLE_DIFX;
          if (n.ext_cnt >= mdrp_pkg::EXT_W'(mdrp_pkg::MAX_EXT)) begin
            n.aborted        = 1'b1;
            res.parse_status = mdrp_pkg::STAT_EXT_OVF;
            n.phase          = mdrp_pkg::PH_DIF;
          end else begin
            n.storage = n.storage | (mdrp_pkg::STOR_W'(b[3:0]) << stor_sh);
            n.subunit = n.subunit | (mdrp_pkg::SUB_W'(b[6]) << n.ext_cnt);
            n.tariff  = n.tariff | (mdrp_pkg::TAR_W'(b[5:4]) << tar_sh);
            n.ext_cnt = n.ext_cnt + mdrp_pkg::EXT_W'(1);
            if (!b[7]) begin
              n.phase = mdrp_pkg::PH_VIF;
            end
          end
        end
        mdrp_pkg::PH_VIF: begin
          res.byte_role = mdrp_pkg::ROLE_VIF;
          n.ext_cnt     = '0;
          if (b[7]) begin
            n.phase = mdrp_pkg::PH_VIFX;
          end else begin
            ve              = end_vif(n, item.last_byte);
            n               = ve.st;
            res.record_done = ve.done;
          end
        end
        mdrp_pkg::PH_VIFX: begin
          res.byte_role = mdrp_pkg::ROLE_VIFX;
          if (n.ext_cnt >= mdrp_pkg::EXT_W'(mdrp_pkg::MAX_EXT)) begin
            n.aborted        = 1'b1;
            res.parse_status = mdrp_pkg::STAT_EXT_OVF;
            n.phase          = mdrp_pkg::PH_DIF;
          end else begin
            n.ext_cnt = n.ext_cnt + mdrp_pkg::EXT_W'(1);
            if (!b[7]) begin
              ve              = end_vif(n, item.last_byte);
              n               = ve.st;
              res.record_done = ve.done;
            end
          end
        end
        mdrp_pkg::PH_DLEN: begin
          res.byte_role = mdrp_pkg::ROLE_DATA;
          n.rec_size    = {1'b0, b} + mdrp_pkg::SIZE_W'(1);
          n.data_rem    = {1'b0, b};
          if (b == 8'd0) begin
            res.record_done = 1'b1;
            n.phase         = mdrp_pkg::PH_DIF;
          end else begin
            n.phase = mdrp_pkg::PH_DATA;
          end
        end
        mdrp_pkg::PH_DATA: begin
          res.byte_role = mdrp_pkg::ROLE_DATA;
          if (n.data_rem != '0) begin
            n.data_rem = n.data_rem - mdrp_pkg::SIZE_W'(1);
          end
          if (n.data_rem == '0) begin
            res.record_done = 1'b1;
            n.phase         = mdrp_pkg::PH_DIF;
          end
        end
        default: begin
          n.phase = mdrp_pkg::PH_DIF;
        end
      endcase
    end

    if (item.last_byte && n.phase != mdrp_pkg::PH_DIF) begin
      res.parse_status = mdrp_pkg::STAT_TRUNC;
      n.phase          = mdrp_pkg::PH_DIF;
    end

    if (snapped) begin
      res.dif_function      = snap.dif_function;
      res.storage_number    = snap.storage_number;
      res.tariff_number     = snap.tariff_number;
      res.subunit_number    = snap.subunit_number;
      res.record_data_size  = snap.record_data_size;
      res.record_data_start = snap.record_data_start;
    end else begin
      res.dif_function      = n.dif_code[5:4];
      res.storage_number    = n.storage;
      res.tariff_number     = n.tariff;
      res.subunit_number    = n.subunit;
      res.record_data_size  = n.rec_size;
      res.record_data_start = mdrp_pkg::START_W'(n.rec_start);
    end

    n.byte_pos = n.byte_pos + mdrp_pkg::POS_W'(1);
    st_nxt     = n;
  end

endmodule

// File: rtl/mbus_data_record_parser_core.sv
// ----------------------------------------------------------------------------
// mbus_data_record_parser_core
// Streaming DIF/VIF/data record parser for decrypted meter payloads.
// ----------------------------------------------------------------------------
// The block takes one payload byte per clock while the output is not stalled
// and returns one tagged result per byte, in order. A byte is held in an input
// register, parsed in a single pass of combinational logic that also advances
// the parser state, and lands in a result register when the stage advances.
// The input accepts a new byte in every cycle while the result register is
// empty or being drained, so the sustained rate is one byte per cycle, set by
// the single-pass state update loop. There is no clearing pass after reset.
module mbus_data_record_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // payload_byte[7:0], control_info[15:8]
  input  logic         in_tuser,   // first_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // dif_function, storage_number, tariff_number,
                                   // subunit_number, record_data_size,
                                   // record_data_start, zero fill
  output logic [5:0]   out_tuser   // byte_role[2:0], record_done[3], parse_status[5:4]
);

  logic              in_vld_r;
  mdrp_pkg::item_t   in_item_r;
  mdrp_pkg::state_t  st_r;
  mdrp_pkg::state_t  st_nxt;
  mdrp_pkg::result_t res_nxt;
  mdrp_pkg::result_t out_res_r;
  logic              out_vld_r;
  logic              advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  mdrp_step u_step (
    .st     (st_r),
    .item   (in_item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= mdrp_pkg::frame_init(mdrp_pkg::MODE_NORMAL);
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        st_r      <= st_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.payload_byte <= in_tdata[7:0];
      in_item_r.control_info <= in_tdata[15:8];
      in_item_r.first_byte   <= in_tuser;
      in_item_r.last_byte    <= in_tlast;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0,
                       out_res_r.record_data_start,
                       out_res_r.record_data_size,
                       out_res_r.subunit_number,
                       out_res_r.tariff_number,
                       out_res_r.storage_number,
                       out_res_r.dif_function};
  assign out_tuser  = {out_res_r.parse_status, out_res_r.record_done, out_res_r.byte_role};

endmodule

// File: verif/mbus_data_record_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbus_data_record_parser_core_tb
// Self-checking testbench for the streaming DIF/VIF/data record parser.
// Payload bytes are sent as single requests through the input stream. A
// behavioral parser in the testbench predicts the tagged result of every
// accepted byte. Each result that leaves the output stream is compared field
// by field with the oldest prediction. Normal, format and compact frames are
// covered, along with broken frames, extension overflow, output back-pressure
// and position wrap.
// ----------------------------------------------------------------------------
module mbus_data_record_parser_core_tb;

  localparam int DATA_LEN_BY_CODE [16] = '{0, 1, 2, 3, 4, 5, 6, 8, 0, 1, 2, 3, 4, 0, 6, 0};

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;   // payload_byte[7:0], control_info[15:8]
  logic         in_tuser;   // first_byte
  logic         in_tlast;   // last_byte
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;  // dif_function, storage_number, tariff_number,
                            // subunit_number, record_data_size, record_data_start
  logic [5:0]   out_tuser;  // byte_role, record_done, parse_status

  mbus_data_record_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mdrp_pkg::result_t expected_results[$];
  logic [7:0]        frame_bytes[$];

  int n_sent     = 0;
  int n_parsed   = 0;
  int n_checked  = 0;
  int n_records  = 0;
  int n_trunc    = 0;
  int n_abort    = 0;
  int mismatches = 0;

  int burst_left = 0;
  bit gaps_on    = 1'b0;
  int sink_style = 0;
  int hold_req   = 0;

  mdrp_pkg::phase_t             prs_phase;
  logic [mdrp_pkg::EXT_W-1:0]   prs_ext;
  logic [mdrp_pkg::SIZE_W-1:0]  prs_remain;
  logic [mdrp_pkg::POS_W-1:0]   prs_pos;
  logic [mdrp_pkg::POS_W-1:0]   prs_fpos;
  logic [1:0]                   prs_skip;
  logic [mdrp_pkg::STOR_W-1:0]  prs_stor;
  logic [mdrp_pkg::TAR_W-1:0]   prs_tar;
  logic [mdrp_pkg::SUB_W-1:0]   prs_sub;
  logic [5:0]                   prs_dif;
  mdrp_pkg::mode_t              prs_mode;
  logic                         prs_abort;
  logic [mdrp_pkg::SIZE_W-1:0]  prs_rsize;
  logic [mdrp_pkg::POS_W-1:0]   prs_rstart;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic stage_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endtask

  task automatic restart_parser(input mdrp_pkg::mode_t m);
    prs_phase  = mdrp_pkg::PH_DIF;
    prs_ext    = '0;
    prs_remain = '0;
    prs_pos    = '0;
    prs_fpos   = mdrp_pkg::POS_W'(4);
    prs_skip   = '0;
    prs_stor   = '0;
    prs_tar    = '0;
    prs_sub    = '0;
    prs_dif    = '0;
    prs_mode   = m;
    prs_abort  = 1'b0;
    prs_rsize  = '0;
    prs_rstart = '0;
  endtask

  function automatic mdrp_pkg::result_t record_view();
    mdrp_pkg::result_t r;
    r = '0;
    r.dif_function      = prs_dif[5:4];
    r.storage_number    = prs_stor;
    r.tariff_number     = prs_tar;
    r.subunit_number    = prs_sub;
    r.record_data_size  = prs_rsize;
    r.record_data_start = prs_rstart;
    return r;
  endfunction

  task automatic finish_vif(input logic last, output logic rec_done);
    logic [3:0] code;
    code = prs_dif[3:0];
    rec_done = 1'b0;
    if (prs_mode == mdrp_pkg::MODE_FORMAT) begin
      prs_rstart = prs_fpos;
      if (code == mdrp_pkg::CODE_VARLEN && !last) begin
        prs_phase = mdrp_pkg::PH_FLEN;
      end else begin
        prs_rsize = (code == mdrp_pkg::CODE_VARLEN) ? mdrp_pkg::SIZE_W'(1)
                                                     : mdrp_pkg::SIZE_W'(DATA_LEN_BY_CODE[code]);
        prs_fpos  = prs_fpos + mdrp_pkg::POS_W'(prs_rsize);
        prs_phase = mdrp_pkg::PH_DIF;
        rec_done  = 1'b1;
      end
    end else begin
      prs_rstart = prs_pos + mdrp_pkg::POS_W'(1);
      if (code == mdrp_pkg::CODE_VARLEN) begin
        prs_phase = mdrp_pkg::PH_DLEN;
      end else begin
        prs_rsize = mdrp_pkg::SIZE_W'(DATA_LEN_BY_CODE[code]);
        if (prs_rsize == '0) begin
          prs_phase = mdrp_pkg::PH_DIF;
          rec_done  = 1'b1;
        end else begin
          prs_remain = prs_rsize;
          prs_phase  = mdrp_pkg::PH_DATA;
        end
      end
    end
  endtask

  task automatic parse_byte(input mdrp_pkg::item_t it, output mdrp_pkg::result_t r);
    logic [7:0]        b;
    mdrp_pkg::role_t   role;
    mdrp_pkg::status_t status;
    logic              rec_done;
    logic              held;
    mdrp_pkg::mode_t   m;
    int                i;
    b        = it.payload_byte;
    role     = mdrp_pkg::ROLE_SKIP;
    status   = mdrp_pkg::STAT_OK;
    rec_done = 1'b0;
    held     = 1'b0;
    r        = '0;
    if (it.first_byte) begin
      case (it.control_info)
        mdrp_pkg::CI_COMPACT_A, mdrp_pkg::CI_COMPACT_B,
        mdrp_pkg::CI_COMPACT_C: m = mdrp_pkg::MODE_COMPACT;
        mdrp_pkg::CI_FORMAT_A, mdrp_pkg::CI_FORMAT_B,
        mdrp_pkg::CI_FORMAT_C:  m = mdrp_pkg::MODE_FORMAT;
        default:                m = mdrp_pkg::MODE_NORMAL;
      endcase
      restart_parser(m);
    end
    if (prs_abort || prs_mode == mdrp_pkg::MODE_COMPACT) begin
      role = mdrp_pkg::ROLE_SKIP;
    end else if (prs_mode == mdrp_pkg::MODE_FORMAT && prs_skip < mdrp_pkg::HDR_SKIP) begin
      prs_skip++;
    end else begin
      // In format frames the length byte closes the pending record and then
      // goes on to be parsed as the next DIF or filler.
      if (prs_phase == mdrp_pkg::PH_FLEN) begin
        prs_rsize = mdrp_pkg::SIZE_W'(b) + mdrp_pkg::SIZE_W'(1);
        prs_fpos  = prs_fpos + mdrp_pkg::POS_W'(prs_rsize);
        rec_done  = 1'b1;
        r         = record_view();
        held      = 1'b1;
        prs_phase = mdrp_pkg::PH_DIF;
      end
      case (prs_phase)
        mdrp_pkg::PH_DIF: begin
          if (b == mdrp_pkg::FILLER_BYTE) begin
            role = mdrp_pkg::ROLE_FILLER;
          end else begin
            role      = mdrp_pkg::ROLE_DIF;
            prs_dif   = b[5:0];
            prs_stor  = mdrp_pkg::STOR_W'(b[6]);
            prs_tar   = '0;
            prs_sub   = '0;
            prs_ext   = '0;
            prs_rsize = '0;
            prs_phase = b[7] ? mdrp_pkg::PH_DIFX : mdrp_pkg::PH_VIF;
          end
        end
        mdrp_pkg::PH_DIFX: begin
          role = mdrp_pkg::ROLE_DIFX;
          if (prs_ext >= mdrp_pkg::MAX_EXT) begin
            prs_abort = 1'b1;
            status    = mdrp_pkg::STAT_EXT_OVF;
            prs_phase = mdrp_pkg::PH_DIF;
          end else begin
            i       = int'(prs_ext);
            prs_ext = prs_ext + mdrp_pkg::EXT_W'(1);
            prs_stor = prs_stor | (mdrp_pkg::STOR_W'(b[3:0]) << (4 * i + 1));
            prs_sub  = prs_sub | (mdrp_pkg::SUB_W'(b[6]) << i);
            prs_tar  = prs_tar | (mdrp_pkg::TAR_W'(b[5:4]) << (2 * i));
            if (!b[7]) prs_phase = mdrp_pkg::PH_VIF;
          end
        end
        mdrp_pkg::PH_VIF: begin
          role    = mdrp_pkg::ROLE_VIF;
          prs_ext = '0;
          if (b[7]) prs_phase = mdrp_pkg::PH_VIFX;
          else finish_vif(it.last_byte, rec_done);
        end
        mdrp_pkg::PH_VIFX: begin
          role = mdrp_pkg::ROLE_VIFX;
          if (prs_ext >= mdrp_pkg::MAX_EXT) begin
            prs_abort = 1'b1;
            status    = mdrp_pkg::STAT_EXT_OVF;
            prs_phase = mdrp_pkg::PH_DIF;
          end else begin
            prs_ext = prs_ext + mdrp_pkg::EXT_W'(1);
            if (!b[7]) finish_vif(it.last_byte, rec_done);
          end
        end
        mdrp_pkg::PH_DLEN: begin
          role       = mdrp_pkg::ROLE_DATA;
          prs_rsize  = mdrp_pkg::SIZE_W'(b) + mdrp_pkg::SIZE_W'(1);
          prs_remain = mdrp_pkg::SIZE_W'(b);
          if (b == 8'h00) begin
            rec_done  = 1'b1;
            prs_phase = mdrp_pkg::PH_DIF;
          end else begin
            prs_phase = mdrp_pkg::PH_DATA;
          end
        end
        mdrp_pkg::PH_DATA: begin
          role = mdrp_pkg::ROLE_DATA;
          if (prs_remain != '0) prs_remain = prs_remain - mdrp_pkg::SIZE_W'(1);
          if (prs_remain == '0) begin
            rec_done  = 1'b1;
            prs_phase = mdrp_pkg::PH_DIF;
          end
        end
        default: prs_phase = mdrp_pkg::PH_DIF;
      endcase
    end
    if (it.last_byte && prs_phase != mdrp_pkg::PH_DIF) begin
      status    = mdrp_pkg::STAT_TRUNC;
      prs_phase = mdrp_pkg::PH_DIF;
    end
    if (!held) r = record_view();
    r.byte_role    = role;
    r.record_done  = rec_done;
    r.parse_status = status;
    prs_pos = prs_pos + mdrp_pkg::POS_W'(1);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic [7:0] ci);
    mdrp_pkg::item_t   it;
    mdrp_pkg::result_t want;
    int                gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {ci, b};
    in_tuser  = first;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    it.payload_byte = b;
    it.first_byte   = first;
    it.last_byte    = last;
    it.control_info = ci;
    parse_byte(it, want);
    expected_results.insert(expected_results.size(), want);
    n_sent++;
    if (want.byte_role != mdrp_pkg::ROLE_SKIP) n_parsed++;
  endtask

  function automatic logic [7:0] pick_ci(input mdrp_pkg::mode_t m);
    logic [7:0] ci;
    case (m)
      mdrp_pkg::MODE_COMPACT: begin
        case ($urandom_range(0, 2))
          0:       ci = mdrp_pkg::CI_COMPACT_A;
          1:       ci = mdrp_pkg::CI_COMPACT_B;
          default: ci = mdrp_pkg::CI_COMPACT_C;
        endcase
      end
      mdrp_pkg::MODE_FORMAT: begin
        case ($urandom_range(0, 2))
          0:       ci = mdrp_pkg::CI_FORMAT_A;
          1:       ci = mdrp_pkg::CI_FORMAT_B;
          default: ci = mdrp_pkg::CI_FORMAT_C;
        endcase
      end
      default: begin
        do ci = 8'($urandom);
        while (ci inside {mdrp_pkg::CI_COMPACT_A, mdrp_pkg::CI_COMPACT_B,
                          mdrp_pkg::CI_COMPACT_C, mdrp_pkg::CI_FORMAT_A,
                          mdrp_pkg::CI_FORMAT_B, mdrp_pkg::CI_FORMAT_C});
      end
    endcase
    return ci;
  endfunction

  task automatic add_record(input mdrp_pkg::mode_t m, input int ext_force);
    logic [7:0] dif;
    logic [7:0] vif;
    logic [7:0] b;
    int         n_dx;
    int         n_vx;
    int         n_data;
    int         k;
    bit         on_vif;
    if ($urandom_range(0, 7) == 0) stage_byte(mdrp_pkg::FILLER_BYTE);
    dif    = 8'($urandom);
    vif    = 8'($urandom);
    on_vif = 1'($urandom_range(0, 1));
    n_dx = !dif[7] ? 0 : ($urandom_range(0, 3) == 0) ? $urandom_range(1, mdrp_pkg::MAX_EXT)
                                                     : $urandom_range(1, 2);
    n_vx = !vif[7] ? 0 : ($urandom_range(0, 3) == 0) ? $urandom_range(1, mdrp_pkg::MAX_EXT)
                                                     : $urandom_range(1, 2);
    if (ext_force != 0) begin
      if (on_vif) n_vx = ext_force;
      else n_dx = ext_force;
    end
    dif[7] = (n_dx != 0);
    vif[7] = (n_vx != 0);
    stage_byte(dif);
    for (k = 0; k < n_dx; k++) begin
      b    = 8'($urandom);
      b[7] = (k < n_dx - 1);
      stage_byte(b);
    end
    stage_byte(vif);
    for (k = 0; k < n_vx; k++) begin
      b    = 8'($urandom);
      b[7] = (k < n_vx - 1);
      stage_byte(b);
    end
    if (m == mdrp_pkg::MODE_NORMAL) begin
      if (dif[3:0] == mdrp_pkg::CODE_VARLEN) begin
        n_data = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        stage_byte(8'(n_data));
      end else begin
        n_data = DATA_LEN_BY_CODE[dif[3:0]];
      end
      repeat (n_data) stage_byte(8'($urandom));
    end
  endtask

  task automatic build_frame(input mdrp_pkg::mode_t m, input int n_rec, input int ext_force);
    int k;
    frame_bytes.delete();
    if (m == mdrp_pkg::MODE_COMPACT) begin
      repeat ($urandom_range(1, 12)) stage_byte(8'($urandom));
    end else begin
      if (m == mdrp_pkg::MODE_FORMAT) repeat (3) stage_byte(8'($urandom));
      for (k = 0; k < n_rec; k++) add_record(m, (k == 0) ? ext_force : 0);
      if ($urandom_range(0, 4) == 0) stage_byte(mdrp_pkg::FILLER_BYTE);
    end
  endtask

  task automatic send_frame(input logic [7:0] ci, input bit with_first, input bit with_last);
    int k;
    int n;
    n = frame_bytes.size();
    for (k = 0; k < n; k++)
      send_byte(frame_bytes[k], with_first && k == 0, with_last && k == n - 1,
                (k == 0) ? ci : 8'($urandom));
  endtask

  task automatic test_directed_bytes();
    gaps_on    = 1'b0;
    sink_style = 0;
    // Bytes ahead of any first mark are parsed in normal mode.
    send_byte(8'h2F, 1'b0, 1'b0, 8'h00);
    send_byte(8'h01, 1'b0, 1'b0, 8'hFF);
    send_byte(8'h13, 1'b0, 1'b0, 8'h00);
    send_byte(8'h5A, 1'b0, 1'b0, 8'h00);
    send_byte(8'h00, 1'b0, 1'b1, 8'h00);
    send_byte(8'hFF, 1'b1, 1'b0, mdrp_pkg::CI_COMPACT_B);
    send_byte(8'h00, 1'b0, 1'b1, 8'h00);
    // Format frame: header skip, full extensions, a length byte that is also
    // a filler, and a variable-length VIF on the last byte.
    send_byte(8'h00, 1'b1, 1'b0, mdrp_pkg::CI_FORMAT_B);
    send_byte(8'hFF, 1'b0, 1'b0, 8'h00);
    send_byte(8'h00, 1'b0, 1'b0, 8'h00);
    send_byte(8'hFD, 1'b0, 1'b0, 8'h00);
    send_byte(8'hFF, 1'b0, 1'b0, 8'h00);
    send_byte(8'h7F, 1'b0, 1'b0, 8'h00);
    send_byte(8'hFF, 1'b0, 1'b0, 8'h00);
    send_byte(8'h00, 1'b0, 1'b0, 8'h00);
    send_byte(8'h2F, 1'b0, 1'b0, 8'h00);
    send_byte(8'h0D, 1'b0, 1'b0, 8'h00);
    send_byte(8'h7F, 1'b0, 1'b1, 8'h00);
    // Normal frame: zero length byte, then a zero-size record.
    send_byte(8'h0D, 1'b1, 1'b0, 8'hC3);
    send_byte(8'h80, 1'b0, 1'b0, 8'h00);
    send_byte(8'h00, 1'b0, 1'b0, 8'h00);
    send_byte(8'h00, 1'b0, 1'b0, 8'h00);
    send_byte(8'h0F, 1'b0, 1'b0, 8'h00);
    send_byte(8'h00, 1'b0, 1'b0, 8'h00);
    send_byte(8'h2F, 1'b0, 1'b1, 8'h00);
  endtask

  task automatic test_random_frames(input int count);
    int              stop_at;
    int              sel;
    int              cut;
    mdrp_pkg::mode_t m;
    stop_at = n_parsed + count;
    while (n_parsed < stop_at) begin
      gaps_on    = ($urandom_range(0, 3) != 0);
      sink_style = $urandom_range(0, 3);
      sel        = $urandom_range(0, 15);
      if (sel < 2) begin
        repeat ($urandom_range(1, 24))
          send_byte(8'($urandom), 1'($urandom_range(0, 7) == 0),
                    1'($urandom_range(0, 7) == 0), 8'($urandom));
      end else begin
        m = (sel < 11) ? mdrp_pkg::MODE_NORMAL :
            (sel < 15) ? mdrp_pkg::MODE_FORMAT : mdrp_pkg::MODE_COMPACT;
        build_frame(m, $urandom_range(1, 6), 0);
        // Some frames are cut short, ending on an open record or running
        // straight into the next first mark.
        if ($urandom_range(0, 5) == 0) begin
          cut = $urandom_range(1, frame_bytes.size());
          frame_bytes = frame_bytes[0:cut-1];
        end
        send_frame(pick_ci(m), $urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0);
      end
    end
  endtask

  task automatic test_extension_overflow();
    int              k;
    mdrp_pkg::mode_t m;
    for (k = 0; k < 8; k++) begin
      gaps_on    = k[0];
      sink_style = k % 4;
      m = (k < 5) ? mdrp_pkg::MODE_NORMAL : mdrp_pkg::MODE_FORMAT;
      build_frame(m, $urandom_range(1, 4), mdrp_pkg::MAX_EXT + (k % 2));
      send_frame(pick_ci(m), 1'b1, 1'b1);
    end
  endtask

  task automatic test_output_backpressure();
    gaps_on    = 1'b0;
    sink_style = 0;
    hold_req   = 300;
    repeat (4) begin
      build_frame(mdrp_pkg::MODE_NORMAL, 6, 0);
      send_frame(pick_ci(mdrp_pkg::MODE_NORMAL), 1'b1, 1'b1);
    end
    sink_style = 3;
    hold_req   = 150;
    repeat (3) begin
      build_frame(mdrp_pkg::MODE_FORMAT, 6, 0);
      send_frame(pick_ci(mdrp_pkg::MODE_FORMAT), 1'b1, 1'b1);
    end
  endtask

  task automatic test_position_wrap();
    int k;
    gaps_on    = 1'b0;
    sink_style = 0;
    // Each length byte of 0xFD adds 254 to the format position and also
    // opens the next record with one DIF extension.
    frame_bytes.delete();
    repeat (3) stage_byte(8'($urandom));
    for (k = 0; k < 260; k++) begin
      stage_byte(8'hFD);
      stage_byte(8'($urandom_range(0, 127)));
      stage_byte(8'($urandom_range(0, 127)));
    end
    send_frame(mdrp_pkg::CI_FORMAT_C, 1'b1, 1'b1);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %0d %s expected %0h got %0h", $time, n_checked, name, want, got);
    end
  endtask

  initial begin : sink_drive
    int tick;
    int hold_left;
    tick       = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        case (sink_style)
          0:       out_tready = 1'b1;
          1:       out_tready = ($urandom_range(0, 3) != 0);
          2:       out_tready = ((tick % 6) < 4);
          default: out_tready = 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin : result_check
    mdrp_pkg::result_t want;
    mdrp_pkg::result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.byte_role         = mdrp_pkg::role_t'(out_tuser[2:0]);
        got.record_done       = out_tuser[3];
        got.parse_status      = mdrp_pkg::status_t'(out_tuser[5:4]);
        got.dif_function      = out_tdata[1:0];
        got.storage_number    = out_tdata[46:2];
        got.tariff_number     = out_tdata[68:47];
        got.subunit_number    = out_tdata[79:69];
        got.record_data_size  = out_tdata[88:80];
        got.record_data_start = out_tdata[104:89];
        n_checked++;
        if (got.record_done) n_records++;
        if (got.parse_status == mdrp_pkg::STAT_TRUNC) n_trunc++;
        if (got.parse_status == mdrp_pkg::STAT_EXT_OVF) n_abort++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d arrived with nothing expected", $time, n_checked);
        end else begin
          want = expected_results.pop_front();
          check_field("byte_role", 64'(want.byte_role), 64'(got.byte_role));
          check_field("record_done", 64'(want.record_done), 64'(got.record_done));
          check_field("dif_function", 64'(want.dif_function), 64'(got.dif_function));
          check_field("storage_number", 64'(want.storage_number), 64'(got.storage_number));
          check_field("tariff_number", 64'(want.tariff_number), 64'(got.tariff_number));
          check_field("subunit_number", 64'(want.subunit_number), 64'(got.subunit_number));
          check_field("record_data_size", 64'(want.record_data_size),
                      64'(got.record_data_size));
          check_field("record_data_start", 64'(want.record_data_start),
                      64'(got.record_data_start));
          check_field("parse_status", 64'(want.parse_status), 64'(got.parse_status));
        end
      end
    end
  end

  initial begin : run_tests
    int spins;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    restart_parser(mdrp_pkg::MODE_NORMAL);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_bytes();
    test_random_frames(200);
    test_extension_overflow();
    test_output_backpressure();
    test_position_wrap();

    @(negedge clk);
    in_tvalid  = 1'b0;
    sink_style = 0;
    spins = 0;
    while (expected_results.size() != 0 && spins < 2000) begin
      @(posedge clk);
      spins++;
    end
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_results.size());
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (%0d parsed) in normal, format and compact frames.",
             n_sent, n_parsed);
    $display("Checked %0d results: %0d records, %0d truncations, %0d overflows, %0d mismatches.",
             n_checked, n_records, n_trunc, n_abort, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
